// File: rtl/spg_pkg.sv
// Package for the softened point-mass gravity block: sizes, codes, reset values,
// saturation helpers and the request structs of the shared divider and root units.
// Depends on nothing; every other file of the block but spg_if.sv uses it by scoped names.
`default_nettype none

package spg_pkg;

   // Axes that are evaluated and the fraction bits of every Q value.
   localparam int DIMS  = 3;
   localparam int FRAC  = 16;
   // Lane storage is rounded up to the reach of a two-bit axis counter.
   localparam int LANES = 4;

   localparam int DIV_STEPS  = 64;
   localparam int SQRT_STEPS = 32;

   localparam logic [30:0] GM_RESET   = 31'(64'd1 << FRAC);
   localparam logic [30:0] CORE_RESET = 31'(64'd1 << FRAC);
   localparam logic [16:0] STEP_RESET = 17'(((64'd1 << FRAC) + 64'd5) / 64'd10);
   localparam logic [31:0] ONE_Q      = 32'(64'd1 << FRAC);

   // Configuration register indexes.
   localparam logic [2:0] CSR_GM     = 3'd0;
   localparam logic [2:0] CSR_CORE   = 3'd1;
   localparam logic [2:0] CSR_STEP   = 3'd2;
   localparam logic [2:0] CSR_ORIG_X = 3'd3;
   localparam logic [2:0] CSR_ORIG_Y = 3'd4;
   localparam logic [2:0] CSR_ORIG_Z = 3'd5;

   // Request kinds.
   localparam logic REQ_NODE   = 1'b0;
   localparam logic REQ_METRIC = 1'b1;

   localparam logic [3:0] METRIC_ENTRIES = 4'd9;

   typedef struct packed {
      logic        start;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] den;
   } div_req_type;

   typedef struct packed {
      logic        start;
      logic [63:0] radicand;
   } sqrt_req_type;

   // Clamp a signed value to the 32-bit signed range.
   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      logic signed [63:0] hi_lim;
      logic signed [63:0] lo_lim;
      hi_lim = 64'sh0000_0000_7FFF_FFFF;
      lo_lim = -64'sh0000_0000_8000_0000;
      if (x > hi_lim) return 32'sh7FFF_FFFF;
      if (x < lo_lim) return 32'sh8000_0000;
      return 32'(x);
   endfunction

   // Magnitude of a signed 32-bit value; the most negative value maps to 2^31.
   function automatic logic [31:0] abs32(input logic signed [31:0] x);
      if (x[31]) return ~x + 32'd1;
      return x;
   endfunction

endpackage

`default_nettype wire

// File: rtl/spg_if.sv
// Channel interfaces of the gravity block: node/metric requests and result beats.
// Plain valid/ready handshake; depends on nothing.
`default_nettype none

interface spg_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [3:0]         metric_index;
   logic signed [31:0] metric_value;
   logic signed [31:0] pos_x;
   logic signed [31:0] pos_y;
   logic signed [31:0] pos_z;
   logic [30:0]        node_mass;
   logic               last_node;

   modport source (output valid, req_type, metric_index, metric_value, pos_x, pos_y,
                   pos_z, node_mass, last_node, input ready);
   modport sink   (input valid, req_type, metric_index, metric_value, pos_x, pos_y,
                   pos_z, node_mass, last_node, output ready);
endinterface

interface spg_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] accel_x;
   logic signed [31:0] accel_y;
   logic signed [31:0] accel_z;
   logic signed [31:0] potential_delta;
   logic signed [47:0] total_potential;
   logic [30:0]        step_limit;
   logic               pass_done;

   modport source (output valid, accel_x, accel_y, accel_z, potential_delta,
                   total_potential, step_limit, pass_done, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, potential_delta,
                   total_potential, step_limit, pass_done, output ready);
endinterface

`default_nettype wire

// File: rtl/softened_point_gravity_core.sv
// Softened point-mass gravity core. Uses spg_pkg, spg_req_if, spg_rsp_if,
// spg_div and spg_sqrt.
//
// Requests arrive on req_bus. A metric beat (req_type 1) writes one entry of the
// 3x3 metric and gives no result. A node beat runs the whole
// evaluation on one 33x33 multiplier, one bit-serial divider and one bit-serial
// square-root unit under a sequencer, and gives exactly one beat on rsp_bus.
// Almost all of a node's time goes to its ten quotients and four roots. When the
// softened radius is zero the divider is skipped. One node is in work at a time;
// req_bus.ready is high only while the sequencer is idle.
// Results sit in an output register. The next request is taken while a result
// still waits there; a stalled receiver only holds up a node that has finished
// and needs the output register.
// The csr_ port writes a register. The user must write only while the block is idle; the block does not enforce it.
// Synchronous reset restores the configuration registers, the identity metric, a zero energy
// total and an all-ones minimum, and empties the output register.
`default_nettype none

module softened_point_gravity_core (
   input  wire         clock,
   input  wire         reset,
   spg_req_if.sink     req_bus,
   spg_rsp_if.source   rsp_bus,
   input  wire         csr_write_en,
   input  wire  [2:0]  csr_index,
   input  wire  [31:0] csr_write_data
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_MAT   = 4'd1;
   localparam logic [3:0] ST_SQR   = 4'd2;
   localparam logic [3:0] ST_RS    = 4'd3;
   localparam logic [3:0] ST_GM    = 4'd4;
   localparam logic [3:0] ST_DIVQ  = 4'd5;
   localparam logic [3:0] ST_AMUL  = 4'd6;
   localparam logic [3:0] ST_ADIV1 = 4'd7;
   localparam logic [3:0] ST_ADIV2 = 4'd8;
   localparam logic [3:0] ST_RM    = 4'd9;
   localparam logic [3:0] ST_RC    = 4'd10;
   localparam logic [3:0] ST_RDIV  = 4'd11;
   localparam logic [3:0] ST_ROOT  = 4'd12;
   localparam logic [3:0] ST_MIN   = 4'd13;
   localparam logic [3:0] ST_STEP  = 4'd14;
   localparam logic [3:0] ST_OUT   = 4'd15;

   localparam int L = spg_pkg::LANES;

   // Configuration registers.
   logic [30:0]        gm_ff;
   logic [30:0]        core_ff;
   logic [16:0]        step_ff;
   logic signed [31:0] orig_ff [0:2];

   // Persistent state.
   logic signed [31:0] metric_ff [0:8];
   logic signed [31:0] metric_in [0:8];
   logic signed [47:0] energy_ff, energy_in;
   logic [31:0]        min_ff, min_in;

   // Sequencer.
   logic [3:0] state_ff, state_in;
   logic       ph_ff, ph_in;
   logic [1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;

   // Working registers.
   logic signed [31:0] d_ff [0:L-1];
   logic signed [31:0] d_in [0:L-1];
   logic signed [31:0] r_ff [0:L-1];
   logic signed [31:0] r_in [0:L-1];
   logic signed [31:0] acc_ff [0:L-1];
   logic signed [31:0] acc_in [0:L-1];
   logic signed [49:0] macc_ff, macc_in;
   logic [63:0]        r2_ff, r2_in;
   logic [63:0]        s2_ff, s2_in;
   logic [31:0]        rs_ff, rs_in;
   logic [63:0]        t_ff, t_in;
   logic [31:0]        num_ff, num_in;
   logic [63:0]        amag_ff, amag_in;
   logic [31:0]        root_ff, root_in;
   logic signed [31:0] dphi_ff, dphi_in;
   logic [30:0]        mass_ff, mass_in;
   logic               last_ff, last_in;
   logic signed [47:0] etot_ff, etot_in;
   logic [31:0]        mincur_ff, mincur_in;
   logic [30:0]        lim_ff, lim_in;
   logic signed [65:0] prod_ff;

   // Output register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] o_ax_ff, o_ay_ff, o_az_ff, o_dphi_ff;
   logic signed [47:0] o_etot_ff;
   logic [30:0]        o_lim_ff;
   logic               o_done_ff;
   logic               out_load;

   // Shared units.
   spg_pkg::div_req_type  div_req;
   spg_pkg::sqrt_req_type sqrt_req;
   logic                  div_done, sqrt_done;
   logic [63:0]           div_quot;
   logic [31:0]           sqrt_root;
   logic [127:0]          div_wide;
   logic [6:0]            div_shift;

   logic signed [32:0] mul_a, mul_b;
   logic [3:0]         midx;
   logic               req_fire;
   logic signed [31:0] pos_v [0:2];
   logic signed [49:0] mat_sum;
   logic [63:0]        r2_next;
   logic signed [48:0] esum;
   logic [31:0]        min_new;
   logic [63:0]        lim_wide;

   spg_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   spg_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .req   (sqrt_req),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_fire      = req_bus.valid && (state_ff == ST_IDLE);
   assign pos_v[0]      = req_bus.pos_x;
   assign pos_v[1]      = req_bus.pos_y;
   assign pos_v[2]      = req_bus.pos_z;
   assign midx          = 4'(i_ff) * 4'd3 + 4'(j_ff);
   assign out_load      = !rsp_valid_ff || rsp_bus.ready;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MAT: begin
            mul_a = 33'(metric_ff[midx]);
            mul_b = 33'(d_ff[j_ff]);
         end
         ST_SQR: begin
            mul_a = 33'(r_ff[k_ff]);
            mul_b = 33'(r_ff[k_ff]);
         end
         ST_GM: begin
            mul_a = {2'b00, gm_ff};
            mul_b = {2'b00, mass_ff};
         end
         ST_AMUL: begin
            mul_a = {2'b00, gm_ff};
            mul_b = {1'b0, num_ff};
         end
         ST_STEP: begin
            mul_a = {16'd0, step_ff};
            mul_b = {1'b0, mincur_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Requests to the divider and the root unit; each wait state starts its unit once.
   always_comb begin
      div_shift = '0;
      div_req.den = '0;
      unique case (state_ff)
         ST_DIVQ: begin
            div_shift   = 7'd0;
            div_req.den = {32'd0, rs_ff};
         end
         ST_ADIV1: begin
            div_shift   = 7'(spg_pkg::FRAC);
            div_req.den = s2_ff;
         end
         ST_ADIV2: begin
            div_shift   = 7'(spg_pkg::FRAC);
            div_req.den = {32'd0, rs_ff};
         end
         ST_RDIV: begin
            div_shift   = 7'(2 * spg_pkg::FRAC);
            div_req.den = amag_ff;
         end
         default: begin
            div_shift   = '0;
            div_req.den = '0;
         end
      endcase
      div_wide      = {64'd0, t_ff} << div_shift;
      div_req.hi    = div_wide[127:64];
      div_req.lo    = div_wide[63:0];
      div_req.start = !ph_ff && ((state_ff == ST_DIVQ) || (state_ff == ST_ADIV1) ||
                                 (state_ff == ST_ADIV2) || (state_ff == ST_RDIV));
   end

   always_comb begin
      sqrt_req.radicand = '0;
      unique case (state_ff)
         ST_RS:   sqrt_req.radicand = s2_ff;
         ST_RM:   sqrt_req.radicand = r2_ff;
         ST_RC:   sqrt_req.radicand = 64'(core_ff) << spg_pkg::FRAC;
         ST_ROOT: sqrt_req.radicand = t_ff;
         default: sqrt_req.radicand = '0;
      endcase
      sqrt_req.start = !ph_ff && ((state_ff == ST_RS) || (state_ff == ST_RM) ||
                                  (state_ff == ST_RC) || (state_ff == ST_ROOT));
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in  = state_ff;
      ph_in     = ph_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      metric_in = metric_ff;
      energy_in = energy_ff;
      min_in    = min_ff;
      d_in      = d_ff;
      r_in      = r_ff;
      acc_in    = acc_ff;
      macc_in   = macc_ff;
      r2_in     = r2_ff;
      s2_in     = s2_ff;
      rs_in     = rs_ff;
      t_in      = t_ff;
      num_in    = num_ff;
      amag_in   = amag_ff;
      root_in   = root_ff;
      dphi_in   = dphi_ff;
      mass_in   = mass_ff;
      last_in   = last_ff;
      etot_in   = etot_ff;
      mincur_in = mincur_ff;
      lim_in    = lim_ff;
      mat_sum   = macc_ff + 50'($signed(prod_ff[63:0]) >>> spg_pkg::FRAC);
      r2_next   = r2_ff + 64'(prod_ff[63:0]);
      esum      = {energy_ff[47], energy_ff} + 49'(dphi_ff);
      min_new   = (root_ff < min_ff) ? root_ff : min_ff;
      lim_wide  = 64'(prod_ff[63:0]) >> spg_pkg::FRAC;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.req_type == spg_pkg::REQ_METRIC) begin
                  if (req_bus.metric_index < spg_pkg::METRIC_ENTRIES) begin
                     metric_in[req_bus.metric_index] = req_bus.metric_value;
                  end
               end else begin
                  // Offset from the point mass, clamped per axis.
                  for (int n = 0; n < L; n++) begin
                     d_in[n]   = '0;
                     r_in[n]   = '0;
                     acc_in[n] = '0;
                  end
                  for (int n = 0; n < spg_pkg::DIMS; n++) begin
                     d_in[n] = spg_pkg::sat32(64'($signed({pos_v[n][31], pos_v[n]} -
                                                          {orig_ff[n][31], orig_ff[n]})));
                  end
                  mass_in  = req_bus.node_mass;
                  last_in  = req_bus.last_node;
                  macc_in  = '0;
                  i_in     = '0;
                  j_in     = '0;
                  ph_in    = 1'b0;
                  state_in = ST_MAT;
               end
            end
         end

         // Metric times offset, one product at a time, summed row by row.
         ST_MAT: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               if (j_ff == 2'(spg_pkg::DIMS - 1)) begin
                  r_in[i_ff] = spg_pkg::sat32(64'(mat_sum));
                  macc_in    = '0;
                  j_in       = '0;
                  if (i_ff == 2'(spg_pkg::DIMS - 1)) begin
                     k_in     = '0;
                     r2_in    = '0;
                     state_in = ST_SQR;
                  end else begin
                     i_in = i_ff + 2'd1;
                  end
               end else begin
                  macc_in = mat_sum;
                  j_in    = j_ff + 2'd1;
               end
            end
         end

         // Squared length and the softened square.
         ST_SQR: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               r2_in = r2_next;
               if (k_ff == 2'(spg_pkg::DIMS - 1)) begin
                  s2_in    = r2_next + (64'(core_ff) << spg_pkg::FRAC);
                  state_in = ST_RS;
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end

         ST_RS: begin
            ph_in = 1'b1;
            if (ph_ff && sqrt_done) begin
               rs_in    = sqrt_root;
               ph_in    = 1'b0;
               state_in = ST_GM;
            end
         end

         // G*m, then either the zero-radius case or the potential quotient.
         ST_GM: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               t_in = prod_ff[63:0];
               if (s2_ff == 64'd0) begin
                  dphi_in  = (prod_ff[63:0] != 64'd0) ? 32'sh8000_0000 : 32'sd0;
                  root_in  = '1;
                  state_in = ST_MIN;
               end else begin
                  state_in = ST_DIVQ;
               end
            end
         end

         ST_DIVQ: begin
            ph_in = 1'b1;
            if (ph_ff && div_done) begin
               dphi_in  = (div_quot >= 64'h8000_0000) ? 32'sh8000_0000 :
                          32'(-div_quot);
               k_in     = '0;
               num_in   = spg_pkg::abs32(r_ff[0]);
               ph_in    = 1'b0;
               state_in = ST_AMUL;
            end
         end

         ST_AMUL: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               t_in     = prod_ff[63:0];
               state_in = ST_ADIV1;
            end
         end

         ST_ADIV1: begin
            ph_in = 1'b1;
            if (ph_ff && div_done) begin
               t_in     = div_quot;
               ph_in    = 1'b0;
               state_in = ST_ADIV2;
            end
         end

         // Acceleration of one axis, or the magnitude on the final round.
         ST_ADIV2: begin
            ph_in = 1'b1;
            if (ph_ff && div_done) begin
               ph_in = 1'b0;
               if (k_ff == 2'(spg_pkg::DIMS)) begin
                  amag_in = div_quot;
                  if (div_quot == 64'd0) begin
                     root_in  = '1;
                     state_in = ST_MIN;
                  end else begin
                     state_in = ST_RC;
                  end
               end else begin
                  if (r_ff[k_ff] > 32'sd0) begin
                     acc_in[k_ff] = (div_quot > 64'h8000_0000) ? 32'sh8000_0000 :
                                    32'(-div_quot);
                  end else if (r_ff[k_ff] < 32'sd0) begin
                     acc_in[k_ff] = (div_quot > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF :
                                    signed'(div_quot[31:0]);
                  end
                  if (k_ff == 2'(spg_pkg::DIMS - 1)) begin
                     state_in = ST_RM;
                  end else begin
                     k_in     = k_ff + 2'd1;
                     num_in   = spg_pkg::abs32(r_ff[k_ff + 2'd1]);
                     state_in = ST_AMUL;
                  end
               end
            end
         end

         ST_RM: begin
            ph_in = 1'b1;
            if (ph_ff && sqrt_done) begin
               num_in   = sqrt_root;
               k_in     = 2'(spg_pkg::DIMS);
               ph_in    = 1'b0;
               state_in = ST_AMUL;
            end
         end

         ST_RC: begin
            ph_in = 1'b1;
            if (ph_ff && sqrt_done) begin
               t_in     = {32'd0, sqrt_root};
               ph_in    = 1'b0;
               state_in = ST_RDIV;
            end
         end

         ST_RDIV: begin
            ph_in = 1'b1;
            if (ph_ff && div_done) begin
               t_in     = div_quot;
               ph_in    = 1'b0;
               state_in = ST_ROOT;
            end
         end

         ST_ROOT: begin
            ph_in = 1'b1;
            if (ph_ff && sqrt_done) begin
               root_in  = sqrt_root;
               ph_in    = 1'b0;
               state_in = ST_MIN;
            end
         end

         // Fold this node into the pass totals; the last node reports and clears them.
         ST_MIN: begin
            ph_in = 1'b0;
            if (esum[48] != esum[47]) begin
               etot_in = esum[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
            end else begin
               etot_in = esum[47:0];
            end
            if (last_ff) begin
               mincur_in = min_new;
               energy_in = '0;
               min_in    = '1;
               state_in  = ST_STEP;
            end else begin
               energy_in = etot_in;
               min_in    = min_new;
               state_in  = ST_OUT;
            end
         end

         ST_STEP: begin
            ph_in = !ph_ff;
            if (ph_ff) begin
               lim_in   = (lim_wide > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : lim_wide[30:0];
               state_in = ST_OUT;
            end
         end

         ST_OUT: begin
            ph_in = 1'b0;
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Output register: loads when empty or when the held beat leaves.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_OUT) && out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // Control state and persistent state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ph_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         energy_ff    <= '0;
         min_ff       <= '1;
         gm_ff        <= spg_pkg::GM_RESET;
         core_ff      <= spg_pkg::CORE_RESET;
         step_ff      <= spg_pkg::STEP_RESET;
         for (int n = 0; n < 3; n++) begin
            orig_ff[n] <= '0;
         end
         for (int n = 0; n < 9; n++) begin
            metric_ff[n] <= ((n % 4) == 0) ? spg_pkg::ONE_Q : 32'sd0;
         end
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         rsp_valid_ff <= rsp_valid_in;
         energy_ff    <= energy_in;
         min_ff       <= min_in;
         metric_ff    <= metric_in;
         if (csr_write_en) begin
            unique case (csr_index)
               spg_pkg::CSR_GM:     gm_ff      <= csr_write_data[30:0];
               spg_pkg::CSR_CORE:   core_ff    <= csr_write_data[30:0];
               spg_pkg::CSR_STEP:   step_ff    <= csr_write_data[16:0];
               spg_pkg::CSR_ORIG_X: orig_ff[0] <= csr_write_data;
               spg_pkg::CSR_ORIG_Y: orig_ff[1] <= csr_write_data;
               spg_pkg::CSR_ORIG_Z: orig_ff[2] <= csr_write_data;
               default: ;
            endcase
         end
      end
   end

   // Working and payload registers.
   always_ff @(posedge clock) begin
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      d_ff      <= d_in;
      r_ff      <= r_in;
      acc_ff    <= acc_in;
      macc_ff   <= macc_in;
      r2_ff     <= r2_in;
      s2_ff     <= s2_in;
      rs_ff     <= rs_in;
      t_ff      <= t_in;
      num_ff    <= num_in;
      amag_ff   <= amag_in;
      root_ff   <= root_in;
      dphi_ff   <= dphi_in;
      mass_ff   <= mass_in;
      last_ff   <= last_in;
      etot_ff   <= etot_in;
      mincur_ff <= mincur_in;
      lim_ff    <= lim_in;
      prod_ff   <= mul_a * mul_b;
      if ((state_ff == ST_OUT) && out_load) begin
         o_ax_ff   <= acc_ff[0];
         o_ay_ff   <= acc_ff[1];
         o_az_ff   <= acc_ff[2];
         o_dphi_ff <= dphi_ff;
         o_etot_ff <= last_ff ? etot_ff : 48'sd0;
         o_lim_ff  <= last_ff ? lim_ff : 31'd0;
         o_done_ff <= last_ff;
      end
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.accel_x         = o_ax_ff;
   assign rsp_bus.accel_y         = o_ay_ff;
   assign rsp_bus.accel_z         = o_az_ff;
   assign rsp_bus.potential_delta = o_dphi_ff;
   assign rsp_bus.total_potential = o_etot_ff;
   assign rsp_bus.step_limit      = o_lim_ff;
   assign rsp_bus.pass_done       = o_done_ff;

   // A result beat only ever appears after the sequencer has reached its output step.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result beat raised outside the output step");

   // The divider only finishes while the sequencer waits on it.
   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVQ || state_ff == ST_ADIV1 ||
                    state_ff == ST_ADIV2 || state_ff == ST_RDIV))
      else $error("divider finished outside a division step");

   // An accepted node closes the request side on the next cycle.
   a_node_busy: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.req_type == spg_pkg::REQ_NODE) |=> !req_bus.ready)
      else $error("request side still open while a node is in work");

endmodule

`default_nettype wire

// File: rtl/spg_div.sv
// Bit-serial restoring divider: floor({hi,lo} / den), one quotient bit a cycle.
// Saturates to all ones when den is zero or the quotient would not fit in 64 bits. Uses spg_pkg.
`default_nettype none

module spg_div (
   input  wire                      clock,
   input  wire                      reset,
   input  spg_pkg::div_req_type     req,
   output logic                     done,
   output logic [63:0]              quot
);

   localparam int CW = $clog2(spg_pkg::DIV_STEPS);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [63:0]   rem_ff, rem_in;
   logic [63:0]   num_ff, num_in;
   logic [63:0]   den_ff, den_in;
   logic [63:0]   quot_ff, quot_in;
   logic [64:0]   shifted;
   logic          take;

   // One step of long division: bring down the next numerator bit and trial-subtract.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      shifted = {rem_ff, num_ff[63]};
      take    = (shifted >= {1'b0, den_ff});
      if (req.start) begin
         if ((req.den == 64'd0) || (req.hi >= req.den)) begin
            quot_in = '1;
            done_in = 1'b1;
            busy_in = 1'b0;
         end else begin
            rem_in  = req.hi;
            num_in  = req.lo;
            den_in  = req.den;
            quot_in = '0;
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = take ? 64'(shifted - {1'b0, den_ff}) : shifted[63:0];
         num_in  = {num_ff[62:0], 1'b0};
         quot_in = {quot_ff[62:0], take};
         cnt_in  = cnt_ff + CW'(1);
         if (cnt_ff == CW'(spg_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      num_ff  <= num_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

`default_nettype wire

// File: rtl/spg_sqrt.sv
// Bit-serial integer square root: floor(sqrt(x)) of a 64-bit value, two bits a cycle.
// Uses spg_pkg for the request struct and step count.
`default_nettype none

module spg_sqrt (
   input  wire                      clock,
   input  wire                      reset,
   input  spg_pkg::sqrt_req_type    req,
   output logic                     done,
   output logic [31:0]              root
);

   localparam int CW = $clog2(spg_pkg::SQRT_STEPS);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [63:0]   rad_ff, rad_in;
   logic [63:0]   res_ff, res_in;
   logic [63:0]   bit_ff, bit_in;
   logic [63:0]   trial;

   // Digit-by-digit root: trial-subtract res+bit, then move bit down two places.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      trial   = res_ff + bit_ff;
      if (req.start) begin
         rad_in  = req.radicand;
         res_in  = '0;
         bit_in  = 64'd1 << 62;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (rad_ff >= trial) begin
            rad_in = rad_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(spg_pkg::SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rad_ff <= rad_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

`default_nettype wire

// File: tb/sv/tb_softened_point_gravity_core.sv
// Self-checking testbench for softened_point_gravity_core: node and metric beats are
// driven in, every result beat is compared with a bit-exact predictor held here.
// Depends on spg_pkg, spg_req_if and spg_rsp_if from the RTL.
`timescale 1ns / 100ps

module tb_softened_point_gravity_core;

   localparam int CYCLE_LIMIT  = 4_000_000;
   localparam int NODE_LATENCY = 1000;

   typedef struct {
      logic               req_type;
      logic [3:0]         metric_index;
      logic signed [31:0] metric_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [30:0]        node_mass;
      logic               last_node;
   } gravity_req_type;

   typedef struct {
      logic signed [31:0] accel_x;
      logic signed [31:0] accel_y;
      logic signed [31:0] accel_z;
      logic signed [31:0] potential_delta;
      logic signed [47:0] total_potential;
      logic [30:0]        step_limit;
      logic               pass_done;
   } gravity_rsp_type;

   logic        clock;
   logic        reset;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_write_data;

   spg_req_if req ();
   spg_rsp_if rsp ();

   softened_point_gravity_core uut (
      .clock(clock),
      .reset(reset),
      .req_bus(req.sink),
      .rsp_bus(rsp.source),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Mirror of the block's registers and state.
   logic [30:0]      mirror_gm;
   logic [30:0]      mirror_core;
   logic [16:0]      mirror_step;
   longint           mirror_origin [3];
   longint           mirror_metric [9];
   longint           mirror_energy;
   logic [63:0]      mirror_min_root;

   gravity_rsp_type  expected_gravity_q [$];
   int               error_count;
   int               cycle_count;
   int               send_idle_pct;
   int               recv_stall_pct;
   int               hold_cycles;
   logic             hold_on;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Long receiver hold-off, timed in its own process.
   initial begin
      hold_on = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            hold_on <= 1'b1;
            repeat (hold_cycles) @(posedge clock);
            hold_on <= 1'b0;
            hold_cycles = 0;
         end
      end
   end

   // Receiver: random stalls plus the hold-off.
   always @(posedge clock) begin
      rsp.ready <= !hold_on && ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic longint clamp_signed(input longint x, input int w);
      longint hi_lim;
      longint lo_lim;
      hi_lim = (longint'(1) <<< (w - 1)) - 1;
      lo_lim = -(longint'(1) <<< (w - 1));
      if (x > hi_lim) return hi_lim;
      if (x < lo_lim) return lo_lim;
      return x;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] res;
      logic [63:0] bit_v;
      res = 64'd0;
      bit_v = 64'd1 << 62;
      while (bit_v > x) bit_v = bit_v >> 2;
      while (bit_v != 0) begin
         if (x >= res + bit_v) begin
            x = x - (res + bit_v);
            res = (res >> 1) + bit_v;
         end else begin
            res = res >> 1;
         end
         bit_v = bit_v >> 2;
      end
      return res;
   endfunction

   // floor(a*b*2^sh/d), saturating at 64 bits; a zero divisor saturates.
   function automatic logic [63:0] scaled_quotient(input logic [63:0] a, input logic [63:0] b,
                                                   input int sh, input logic [63:0] d);
      logic [191:0] num;
      logic [191:0] quo;
      if (d == 0) return '1;
      num = ({128'd0, a} * {128'd0, b}) << sh;
      quo = num / {128'd0, d};
      if (quo[191:64] != 0) return '1;
      return quo[63:0];
   endfunction

   function automatic logic [63:0] accel_magnitude(input logic [63:0] num,
                                                   input logic [63:0] s2,
                                                   input logic [63:0] rs);
      logic [63:0] t;
      t = scaled_quotient({33'd0, mirror_gm}, num, spg_pkg::FRAC, s2);
      return scaled_quotient(t, 64'd1, spg_pkg::FRAC, rs);
   endfunction

   // Works out the result of one accepted beat; metric beats update the table only.
   function automatic bit gravity_predict(input gravity_req_type item,
                                          output gravity_rsp_type res);
      longint      d [3];
      longint      r [3];
      longint      acc [3];
      longint      pos [3];
      longint      sum;
      longint      dphi;
      logic [63:0] r2, s2, rs, gm, q, mag, a, amag, rc, root, lim;
      res = '{default: '0};
      if (item.req_type == spg_pkg::REQ_METRIC) begin
         if (item.metric_index < spg_pkg::METRIC_ENTRIES)
            mirror_metric[item.metric_index] = longint'(item.metric_value);
         return 1'b0;
      end
      pos[0] = longint'(item.pos_x);
      pos[1] = longint'(item.pos_y);
      pos[2] = longint'(item.pos_z);
      for (int j = 0; j < spg_pkg::DIMS; j++)
         d[j] = clamp_signed(pos[j] - mirror_origin[j], 32);
      r2 = 64'd0;
      for (int i = 0; i < spg_pkg::DIMS; i++) begin
         sum = 0;
         for (int j = 0; j < spg_pkg::DIMS; j++)
            sum += (mirror_metric[i * 3 + j] * d[j]) >>> spg_pkg::FRAC;
         r[i] = clamp_signed(sum, 32);
         r2 += 64'(r[i] * r[i]);
         acc[i] = 0;
      end
      s2 = r2 + ({33'd0, mirror_core} << spg_pkg::FRAC);
      rs = int_sqrt(s2);
      gm = {33'd0, mirror_gm} * {33'd0, item.node_mass};
      if (rs == 0) q = (gm != 0) ? (64'd1 << 31) : 64'd0;
      else q = gm / rs;
      if (q > (64'd1 << 31)) q = 64'd1 << 31;
      dphi = -longint'(q);

      // The divider is bypassed when the softened radius is zero.
      if (s2 != 0) begin
         for (int i = 0; i < spg_pkg::DIMS; i++) begin
            mag = (r[i] < 0) ? 64'(-r[i]) : 64'(r[i]);
            a = accel_magnitude(mag, s2, rs);
            if (r[i] > 0) acc[i] = (a > (64'd1 << 31)) ? -(longint'(1) <<< 31) : -longint'(a);
            else if (r[i] < 0) acc[i] = (a > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : longint'(a);
         end
         amag = accel_magnitude(int_sqrt(r2), s2, rs);
      end else begin
         amag = 64'd0;
      end

      // A zero acceleration places no limit on the step.
      if (amag == 0) begin
         root = 64'hFFFF_FFFF;
      end else begin
         rc = int_sqrt({33'd0, mirror_core} << spg_pkg::FRAC);
         root = int_sqrt(scaled_quotient(rc, 64'd1, 2 * spg_pkg::FRAC, amag));
         if (root > 64'hFFFF_FFFF) root = 64'hFFFF_FFFF;
      end
      if (root < mirror_min_root) mirror_min_root = root;
      mirror_energy = clamp_signed(mirror_energy + dphi, 48);

      res.accel_x = 32'(acc[0]);
      res.accel_y = 32'(acc[1]);
      res.accel_z = 32'(acc[2]);
      res.potential_delta = 32'(dphi);
      if (item.last_node) begin
         lim = ({47'd0, mirror_step} * mirror_min_root) >> spg_pkg::FRAC;
         if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
         res.total_potential = 48'(mirror_energy);
         res.step_limit = lim[30:0];
         res.pass_done = 1'b1;
         mirror_energy = 0;
         mirror_min_root = 64'hFFFF_FFFF;
      end
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH at cycle %0d: %s got %h expected %h", cycle_count, field, got, want);
      error_count++;
   endtask

   // Result checker: each beat against the oldest expectation.
   always @(posedge clock) begin
      gravity_rsp_type want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (expected_gravity_q.size() == 0) begin
            report_mismatch("unexpected result beat", 64'd1, 64'd0);
         end else begin
            want = expected_gravity_q.pop_front();
            if (rsp.accel_x !== want.accel_x)
               report_mismatch("accel_x", 64'(rsp.accel_x), 64'(want.accel_x));
            if (rsp.accel_y !== want.accel_y)
               report_mismatch("accel_y", 64'(rsp.accel_y), 64'(want.accel_y));
            if (rsp.accel_z !== want.accel_z)
               report_mismatch("accel_z", 64'(rsp.accel_z), 64'(want.accel_z));
            if (rsp.potential_delta !== want.potential_delta)
               report_mismatch("potential_delta", 64'(rsp.potential_delta),
                               64'(want.potential_delta));
            if (rsp.total_potential !== want.total_potential)
               report_mismatch("total_potential", 64'(rsp.total_potential),
                               64'(want.total_potential));
            if (rsp.step_limit !== want.step_limit)
               report_mismatch("step_limit", 64'(rsp.step_limit), 64'(want.step_limit));
            if (rsp.pass_done !== want.pass_done)
               report_mismatch("pass_done", 64'(rsp.pass_done), 64'(want.pass_done));
         end
      end
   end

   // Offers one beat and predicts at acceptance; valid stays high unless a gap follows.
   task automatic send_beat(input gravity_req_type item);
      gravity_rsp_type res;
      int gap;
      req.valid        <= 1'b1;
      req.req_type     <= item.req_type;
      req.metric_index <= item.metric_index;
      req.metric_value <= item.metric_value;
      req.pos_x        <= item.pos_x;
      req.pos_y        <= item.pos_y;
      req.pos_z        <= item.pos_z;
      req.node_mass    <= item.node_mass;
      req.last_node    <= item.last_node;
      do @(posedge clock); while (req.ready !== 1'b1);
      if (gravity_predict(item, res)) expected_gravity_q.push_back(res);
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every expected result has come back.
   task automatic drain_results();
      req.valid <= 1'b0;
      while (expected_gravity_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      case (idx)
         spg_pkg::CSR_GM:     mirror_gm = data[30:0];
         spg_pkg::CSR_CORE:   mirror_core = data[30:0];
         spg_pkg::CSR_STEP:   mirror_step = data[16:0];
         spg_pkg::CSR_ORIG_X: mirror_origin[0] = longint'($signed(data));
         spg_pkg::CSR_ORIG_Y: mirror_origin[1] = longint'($signed(data));
         spg_pkg::CSR_ORIG_Z: mirror_origin[2] = longint'($signed(data));
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all_registers(input logic [31:0] gm, input logic [31:0] core,
                                      input logic [31:0] step, input logic [31:0] ox,
                                      input logic [31:0] oy, input logic [31:0] oz);
      write_register(spg_pkg::CSR_GM, gm);
      write_register(spg_pkg::CSR_CORE, core);
      write_register(spg_pkg::CSR_STEP, step);
      write_register(spg_pkg::CSR_ORIG_X, ox);
      write_register(spg_pkg::CSR_ORIG_Y, oy);
      write_register(spg_pkg::CSR_ORIG_Z, oz);
   endtask

   function automatic gravity_req_type node_beat(input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic signed [31:0] z,
                                                 input logic [30:0] mass, input logic last);
      gravity_req_type item;
      item.req_type = spg_pkg::REQ_NODE;
      item.metric_index = 4'($urandom);
      item.metric_value = $urandom;
      item.pos_x = x;
      item.pos_y = y;
      item.pos_z = z;
      item.node_mass = mass;
      item.last_node = last;
      return item;
   endfunction

   function automatic gravity_req_type metric_beat(input logic [3:0] idx,
                                                   input logic signed [31:0] value);
      gravity_req_type item;
      item = node_beat($urandom, $urandom, $urandom, 31'($urandom), 1'($urandom));
      item.req_type = spg_pkg::REQ_METRIC;
      item.metric_index = idx;
      item.metric_value = value;
      return item;
   endfunction

   // A coordinate either near the origin or anywhere in range.
   function automatic logic signed [31:0] rand_coord(input int axis);
      if ($urandom_range(2) == 0) return $urandom;
      return 32'(mirror_origin[axis]) + $signed(32'($urandom_range(1 << 22)) - (1 << 21));
   endfunction

   function automatic gravity_req_type rand_item();
      logic signed [31:0] value;
      if ($urandom_range(9) == 0) begin
         if ($urandom_range(3) == 0) value = $urandom;
         else value = $signed(32'($urandom_range(1 << 18)) - (1 << 17));
         return metric_beat(4'($urandom_range(15)), value);
      end
      return node_beat(rand_coord(0), rand_coord(1), rand_coord(2),
                       ($urandom_range(1) == 0) ? 31'($urandom) : 31'($urandom_range(1 << 20)),
                       $urandom_range(7) == 0);
   endfunction

   // Extreme positions and masses under the reset settings, with the identity metric.
   task automatic test_field_extremes();
      send_beat(node_beat(32'sd0, 32'sd0, 32'sd0, 31'd65536, 1'b0));
      send_beat(node_beat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '1, 1'b0));
      send_beat(node_beat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, '1, 1'b0));
      send_beat(node_beat(32'sh0001_0000, -32'sh0002_0000, 32'sh0000_8000, 31'd1, 1'b1));
      send_beat(node_beat(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 31'd0, 1'b1));
      drain_results();
   endtask

   // Zero core and zero offset: the softened radius vanishes; then zero G with the largest core.
   task automatic test_zero_radius();
      write_all_registers(32'hFFFF_FFFF, 32'd0, 32'd65536, 32'sh8000_0000,
                          32'sh7FFF_FFFF, 32'd0);
      write_register(3'd6, $urandom);
      write_register(3'd7, $urandom);
      send_beat(node_beat(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, 31'd5, 1'b0));
      send_beat(node_beat(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0, 31'd0, 1'b1));
      send_beat(node_beat(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd3, '1, 1'b1));
      drain_results();
      write_all_registers(32'd0, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 32'd0);
      send_beat(node_beat(32'sh0100_0000, 32'sd0, -32'sd5, '1, 1'b1));
      drain_results();
   endtask

   // Metric entries, including indexes past the table that must be ignored.
   task automatic test_metric_writes();
      write_all_registers(32'h0001_0000, 32'h0001_0000, 32'd6554, 32'd0, 32'd0, 32'd0);
      send_beat(metric_beat(4'd0, 32'sh7FFF_FFFF));
      send_beat(metric_beat(4'd4, 32'sh8000_0000));
      send_beat(metric_beat(4'd8, -32'sh0001_0000));
      send_beat(metric_beat(4'd1, 32'sh0000_8000));
      send_beat(metric_beat(4'd9, 32'sh1234_5678));
      send_beat(metric_beat(4'd15, 32'sh8765_4321));
      send_beat(node_beat(32'sh0003_0000, 32'sh0007_0000, -32'sh0002_0000, 31'd99, 1'b0));
      send_beat(node_beat(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'd7, 1'b1));
      for (int i = 0; i < 9; i++)
         send_beat(metric_beat(4'(i), (i % 4 == 0) ? 32'sh0001_0000 : 32'sd0));
      drain_results();
   endtask

   // Random items under one register setting and one idling mix.
   task automatic test_random_phase(input int sender_pct, input int receiver_pct,
                                    input int items, input logic [31:0] gm,
                                    input logic [31:0] core, input logic [31:0] step,
                                    input logic [31:0] ox, input logic [31:0] oy,
                                    input logic [31:0] oz);
      write_all_registers(gm, core, step, ox, oy, oz);
      send_idle_pct = sender_pct;
      recv_stall_pct = receiver_pct;
      for (int i = 0; i < items; i++) send_beat(rand_item());
      drain_results();
   endtask

   // Receiver holds off while nodes keep coming, so the input backs up.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 3000;
      for (int i = 0; i < 6; i++) send_beat(rand_item());
      drain_results();
   endtask

   initial begin
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = 3'd0;
      csr_write_data = 32'd0;
      req.valid = 1'b0;
      req.req_type = spg_pkg::REQ_NODE;
      req.metric_index = 4'd0;
      req.metric_value = 32'sd0;
      req.pos_x = 32'sd0;
      req.pos_y = 32'sd0;
      req.pos_z = 32'sd0;
      req.node_mass = 31'd0;
      req.last_node = 1'b0;
      rsp.ready = 1'b0;
      error_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_cycles = 0;
      mirror_gm = spg_pkg::GM_RESET;
      mirror_core = spg_pkg::CORE_RESET;
      mirror_step = spg_pkg::STEP_RESET;
      for (int i = 0; i < 3; i++) mirror_origin[i] = 0;
      for (int i = 0; i < 9; i++)
         mirror_metric[i] = (i % 4 == 0) ? longint'(spg_pkg::ONE_Q) : 0;
      mirror_energy = 0;
      mirror_min_root = 64'hFFFF_FFFF;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_zero_radius();
      test_metric_writes();
      test_random_phase(0, 0, 220, 32'h0001_0000, 32'h0001_0000, 32'd6554,
                        32'd0, 32'd0, 32'd0);
      test_random_phase(61, 0, 220, 32'h7FFF_FFFF, 32'd1, 32'd65536,
                        $urandom, $urandom, $urandom);
      test_backpressure();
      test_random_phase(0, 61, 220, $urandom, $urandom_range(1 << 20), $urandom_range(65536),
                        32'sh7FFF_FFFF, 32'sh8000_0000, 32'd0);
      test_random_phase(23, 23, 220, 32'd1, 32'h7FFF_FFFF, 32'd0,
                        32'sh8000_0000, 32'sh7FFF_FFFF, $urandom);

      drain_results();
      repeat (NODE_LATENCY) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/spg_pkg.sv
rtl/spg_if.sv
rtl/spg_div.sv
rtl/spg_sqrt.sv
rtl/softened_point_gravity_core.sv
tb/sv/tb_softened_point_gravity_core.sv
